/* rtl/lcdns_pkg.sv */
// shared types, codes and constants for the character lcd nibble sequencer
package lcdns_pkg;

    localparam int WaitW   = 16;
    localparam int PulseW  = 10;
    localparam int HoldW   = 17;
    localparam int CfgIdxW = 3;

    localparam logic [WaitW-1:0]  PowerUpReset = 16'd30000;
    localparam logic [WaitW-1:0]  InitGapReset = 16'd10000;
    localparam logic [WaitW-1:0]  ClearReset   = 16'd2000;
    localparam logic [PulseW-1:0] SetupReset   = 10'd10;
    localparam logic [PulseW-1:0] HighReset    = 10'd10;
    localparam logic [PulseW-1:0] SettleReset  = 10'd100;

    localparam logic [7:0] CmdClear  = 8'h01;
    localparam logic [7:0] CmdHome   = 8'h02;
    localparam logic [7:0] Line1Addr = 8'h80;
    localparam logic [7:0] Line2Addr = 8'hC0;
    localparam logic [3:0] InitNibA  = 4'h3;
    localparam logic [3:0] InitNibB  = 4'h2;

    typedef enum logic [2:0] {
        REQ_INIT   = 3'd0,
        REQ_CMD    = 3'd1,
        REQ_CHAR   = 3'd2,
        REQ_CURSOR = 3'd3,
        REQ_CLEAR  = 3'd4,
        REQ_HOME   = 3'd5
    } req_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_POWER_UP  = 3'd0,
        CFG_INIT_GAP  = 3'd1,
        CFG_CLEAR     = 3'd2,
        CFG_EN_SETUP  = 3'd3,
        CFG_EN_HIGH   = 3'd4,
        CFG_EN_SETTLE = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POWER,
        S_PULSE
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_POWER,
        PH_SETUP,
        PH_HIGH,
        PH_SETTLE
    } phase_t;

    typedef enum logic [1:0] {
        EX_NONE,
        EX_GAP,
        EX_CLEAR
    } extra_t;

    typedef struct packed {
        logic       emit;
        phase_t     ph;
        extra_t     ex;
        logic [1:0] nib_idx;
        logic       en;
        logic       last;
    } step_t;

    typedef struct packed {
        logic [WaitW-1:0]  power_up;
        logic [WaitW-1:0]  init_gap;
        logic [WaitW-1:0]  clear_wait;
        logic [PulseW-1:0] en_setup;
        logic [PulseW-1:0] en_high;
        logic [PulseW-1:0] en_settle;
    } cfg_t;

endpackage

/* rtl/lcdns_hold_unit.sv */
// shared hold time adder: base time of the current phase plus extra wait
module lcdns_hold_unit (
    input  lcdns_pkg::cfg_t             cfg,
    input  lcdns_pkg::phase_t           ph,
    input  lcdns_pkg::extra_t           ex,
    output logic [lcdns_pkg::HoldW-1:0] hold_us
);
    import lcdns_pkg::*;

    logic [WaitW-1:0] base;
    logic [WaitW-1:0] extra;

    always_comb begin
        case (ph)
            PH_POWER:  base = cfg.power_up;
            PH_SETUP:  base = WaitW'(cfg.en_setup);
            PH_HIGH:   base = WaitW'(cfg.en_high);
            PH_SETTLE: base = WaitW'(cfg.en_settle);
            default:   base = '0;
        endcase
        case (ex)
            EX_GAP:   extra = cfg.init_gap;
            EX_CLEAR: extra = cfg.clear_wait;
            default:  extra = '0;
        endcase
    end

    assign hold_us = HoldW'(base) + HoldW'(extra);

endmodule

/* rtl/lcdns_seq.sv */
// step sequencer: walks the power-up state and the three-state enable pulses
module lcdns_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                start_init,
    input  logic                start_clr,
    input  logic                adv,
    output logic                idle,
    output lcdns_pkg::step_t    step
);
    import lcdns_pkg::*;

    seq_state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] nib_reg, nib_next;
    logic       init_reg, init_next;
    logic       clr_reg, clr_next;
    logic       last_nib;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= '0;
            nib_reg   <= '0;
            init_reg  <= 1'b0;
            clr_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
            init_reg  <= init_next;
            clr_reg   <= clr_next;
        end
    end

    // init sends four nibbles, a byte two
    assign last_nib = init_reg ? (nib_reg == 2'd3) : (nib_reg == 2'd1);
    assign idle     = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        nib_next     = nib_reg;
        init_next    = init_reg;
        clr_next     = clr_reg;
        step         = '0;
        step.ph      = PH_POWER;
        step.ex      = EX_NONE;
        step.nib_idx = nib_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    init_next  = start_init;
                    clr_next   = start_clr;
                    phase_next = '0;
                    nib_next   = '0;
                    state_next = start_init ? S_POWER : S_PULSE;
                end
            end
            S_POWER: begin
                step.emit = adv;
                if (adv) begin
                    state_next = S_PULSE;
                end
            end
            S_PULSE: begin
                step.emit = adv;
                case (phase_reg)
                    2'd0:    step.ph = PH_SETUP;
                    2'd1:    step.ph = PH_HIGH;
                    default: step.ph = PH_SETTLE;
                endcase
                step.en = (phase_reg == 2'd1);
                if (phase_reg == 2'd2) begin
                    if (init_reg && !nib_reg[1]) begin
                        step.ex = EX_GAP;
                    end else if (!init_reg && clr_reg && last_nib) begin
                        step.ex = EX_CLEAR;
                    end
                    step.last = last_nib;
                end
                if (adv) begin
                    if (phase_reg == 2'd2) begin
                        phase_next = '0;
                        nib_next   = nib_reg + 2'd1;
                        if (last_nib) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* rtl/char_lcd_nibble_sequencer.sv */
// top level of the character lcd nibble sequencer
// the first pin state of an accepted request shows on m_tvalid after the sequencer
// state register and the output register; throughput: one pin state per cycle while
//   m_tready is high; a byte request gives 6 states and init gives 13 states
// the step sequencer and the single hold adder set that rate; s_tready is low meanwhile
// reset: synchronous active-low aresetn clears control state and loads register defaults
module char_lcd_nibble_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // byte_value[7:0], line_number[9:8], column_number[15:10]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_write[0], enable_pin[1], data_nibble[5:2],
                                   // hold_us[22:6], zero[23]
    output logic [0:0]  m_tuser,   // reg_select[0]
    output logic        m_tlast,   // last_state
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lcdns_pkg::*;

    cfg_t        cfg_reg;
    logic [7:0]  byte_reg, byte_next;
    logic        rs_reg, rs_next;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;

    logic [7:0]       in_byte;
    logic [1:0]       in_line;
    logic [5:0]       in_col;
    logic [7:0]       cur_addr;
    logic             in_accept;
    logic             req_ok;
    logic             adv;
    logic             idle;
    step_t            step;
    logic [3:0]       nibble;
    logic [HoldW-1:0] hold_us;

    assign in_byte  = s_tdata[7:0];
    assign in_line  = s_tdata[9:8];
    assign in_col   = s_tdata[15:10];
    assign cur_addr = {2'b00, in_col} - 8'd1;

    assign cfg_ready = 1'b1;
    assign s_tready  = idle;
    assign in_accept = s_tvalid && s_tready;
    assign adv       = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_up   <= PowerUpReset;
            cfg_reg.init_gap   <= InitGapReset;
            cfg_reg.clear_wait <= ClearReset;
            cfg_reg.en_setup   <= SetupReset;
            cfg_reg.en_high    <= HighReset;
            cfg_reg.en_settle  <= SettleReset;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_POWER_UP:  cfg_reg.power_up   <= cfg_data;
                CFG_INIT_GAP:  cfg_reg.init_gap   <= cfg_data;
                CFG_CLEAR:     cfg_reg.clear_wait <= cfg_data;
                CFG_EN_SETUP:  cfg_reg.en_setup   <= cfg_data[PulseW-1:0];
                CFG_EN_HIGH:   cfg_reg.en_high    <= cfg_data[PulseW-1:0];
                CFG_EN_SETTLE: cfg_reg.en_settle  <= cfg_data[PulseW-1:0];
                default: ;
            endcase
        end
    end

    // decode the request into the byte to send
    always_comb begin
        byte_next = byte_reg;
        rs_next   = rs_reg;
        req_ok    = 1'b1;
        case (s_tuser)
            REQ_INIT: begin
                byte_next = {InitNibA, InitNibA};
            end
            REQ_CMD: begin
                byte_next = in_byte;
                rs_next   = 1'b0;
            end
            REQ_CHAR: begin
                byte_next = in_byte;
                rs_next   = 1'b1;
            end
            REQ_CURSOR: begin
                rs_next = 1'b0;
                if (in_line == 2'd1) begin
                    byte_next = cur_addr | Line1Addr;
                end else if (in_line == 2'd2) begin
                    byte_next = cur_addr | Line2Addr;
                end else begin
                    req_ok = 1'b0;
                end
            end
            REQ_CLEAR: begin
                byte_next = CmdClear;
                rs_next   = 1'b0;
            end
            REQ_HOME: begin
                byte_next = CmdHome;
                rs_next   = 1'b0;
            end
            default: req_ok = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_reg <= 1'b0;
        end else if (in_accept) begin
            rs_reg <= (s_tuser == REQ_INIT) ? 1'b0 : rs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            byte_reg <= byte_next;
        end
    end

    lcdns_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (in_accept && req_ok),
        .start_init (s_tuser == REQ_INIT),
        .start_clr  (s_tuser == REQ_CLEAR || s_tuser == REQ_HOME),
        .adv        (adv),
        .idle       (idle),
        .step       (step)
    );

    lcdns_hold_unit u_hold (
        .cfg     (cfg_reg),
        .ph      (step.ph),
        .ex      (step.ex),
        .hold_us (hold_us)
    );

    always_comb begin
        if (step.ph == PH_POWER) begin
            nibble = 4'h0;
        end else if (rs_reg == 1'b0 && step.nib_idx[1]) begin
            // only init reaches nibbles two and three
            nibble = step.nib_idx[0] ? InitNibB : InitNibA;
        end else begin
            nibble = step.nib_idx[0] ? byte_reg[3:0] : byte_reg[7:4];
        end
    end

    // init rides on the nibble index too: the sequencer remembers init and the byte path
    // never asks for nibble index above one, so nibbles zero and one of init need the
    // byte register to hold 0x33
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.emit) begin
            m_tdata_reg <= {1'b0, hold_us, nibble, step.en, 1'b0};
            m_tuser_reg <= (step.ph == PH_POWER) ? 1'b0 : rs_reg;
            m_tlast_reg <= step.last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

/* rtl/char_lcd_nibble_sequencer_chk.sv */
// port-level checker for the character lcd nibble sequencer, bound to the top level
module char_lcd_nibble_sequencer_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_write_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[0] && !m_tdata[23])
        else $error("rw pin or pad bit set");

    a_en_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> !m_tlast)
        else $error("request ended on enable high");

    a_busy_mid_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast && m_tready |-> !s_tready)
        else $error("ready raised before last state of request was produced");

endmodule

bind char_lcd_nibble_sequencer char_lcd_nibble_sequencer_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
